// ===== hw/rtl/dedup_task_queue_with_rescan_macros.svh =====
// Assertion macros for the task queue block.
`ifndef DEDUP_TASK_QUEUE_WITH_RESCAN_MACROS_SVH
`define DEDUP_TASK_QUEUE_WITH_RESCAN_MACROS_SVH
`ifndef SYNTH
`define DTQ_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DTQ_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTQ_ASSERT(label, clk, rstn, prop, msg)
`define DTQ_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and codes for the deduplicating task queue.
// ----------------------------------------------------------------------------
package dtq_pkg;
  localparam int unsigned QueueDepthDefault = 32;

  typedef enum logic [2:0] {
    OP_PUSH_LID = 3'd0,
    OP_PUSH_GID = 3'd1,
    OP_POP      = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_SCHED    = 3'd4,
    OP_TICK     = 3'd5
  } op_e;

  localparam logic [2:0] StAdded   = 3'd0;
  localparam logic [2:0] StDup     = 3'd1;
  localparam logic [2:0] StIgnored = 3'd2;
  localparam logic [2:0] StFlushed = 3'd3;
  localparam logic [2:0] StPopped  = 3'd4;
  localparam logic [2:0] StEmpty   = 3'd5;
  localparam logic [2:0] StDone    = 3'd6;

  // one command transaction handed from front to back
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] lid;
    logic [63:0] gid_high;
    logic [63:0] gid_low;
    logic [15:0] pkey;
    logic [15:0] delay;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] lid;
    logic [63:0] gid_high;
    logic [63:0] gid_low;
    logic [15:0] pkey;
    logic        pending;
    logic [5:0]  held;
    logic        wake;
  } res_t;
endpackage

// ===== hw/rtl/dtq_front.sv =====
// ----------------------------------------------------------------------------
// dtq_front
// Input stage: two-entry command queue between the port and the engine.
// ----------------------------------------------------------------------------
module dtq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  dtq_pkg::cmd_t cmd_i,
  output logic          cvalid_o,
  input  logic          ctake_i,
  output dtq_pkg::cmd_t cmd_o
);
  import dtq_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o   = cnt_q[1];
  assign cvalid_o = (cnt_q != 2'd0);
  assign cmd_o    = mem_q[rp_q];
  assign wr = push_i && !full_o;
  assign rd = ctake_i && cvalid_o;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ===== hw/rtl/dtq_back.sv =====
// ----------------------------------------------------------------------------
// dtq_back
// Engine: entry store with parallel match, shift-out pop, rescan timer,
// and a one-deep result register.
// ----------------------------------------------------------------------------
module dtq_back #(
  parameter int unsigned QueueDepth = dtq_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cvalid_i,
  output logic          ctake_o,
  input  dtq_pkg::cmd_t cmd_i,
  output logic          rvalid_o,
  input  logic          rtake_i,
  output dtq_pkg::res_t res_o
);
  import dtq_pkg::*;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [15:0] e_lid [QueueDepth];
  logic [15:0] e_pk  [QueueDepth];
  logic [63:0] e_gh  [QueueDepth];
  logic [63:0] e_gl  [QueueDepth];

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     now_q, now_d;
  logic [32:0]     nrs_q, nrs_d;
  logic            dis_q, dis_d;
  logic            rv_q;
  res_t            res_q, res_d;
  logic            go, dup, pend, pend_after, is_gid;
  logic            do_add, do_pop;
  logic [15:0]     nlid;
  logic [63:0]     ngh, ngl;

  // a command is taken only while the result register is free
  assign ctake_o  = cvalid_i && !rv_q;
  assign go       = ctake_o;
  assign rvalid_o = rv_q;
  assign res_o    = res_q;

  assign pend    = !dis_q && (nrs_q <= {1'b0, now_q});
  assign is_gid  = (cmd_i.op == OP_PUSH_GID);
  assign nlid = is_gid ? 16'd0 : cmd_i.lid;
  assign ngh  = is_gid ? cmd_i.gid_high : 64'd0;
  assign ngl  = is_gid ? cmd_i.gid_low : 64'd0;

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (i < int'(cnt_q) && e_pk[i] == cmd_i.pkey) begin
        if (is_gid ? (e_gh[i] == cmd_i.gid_high && e_gl[i] == cmd_i.gid_low)
                   : (e_lid[i] == cmd_i.lid)) dup = 1'b1;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q; now_d = now_q; nrs_d = nrs_q; dis_d = dis_q;
    do_add = 1'b0; do_pop = 1'b0;
    res_d = '0;
    res_d.status = StDone;
    case (cmd_i.op)
      OP_PUSH_LID, OP_PUSH_GID: begin
        if (pend) res_d.status = StIgnored;
        else if (dup) res_d.status = StDup;
        else begin
          res_d.wake = 1'b1;
          if (cnt_q == CntW'(QueueDepth)) begin
            res_d.status = StFlushed;
            cnt_d = '0; dis_d = 1'b0; nrs_d = {1'b0, now_q};
          end else begin
            res_d.status = StAdded;
            do_add = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      OP_POP: begin
        if (cnt_q == '0) res_d.status = StEmpty;
        else begin
          res_d.status   = StPopped;
          res_d.lid      = e_lid[0];
          res_d.pkey     = e_pk[0];
          res_d.gid_high = e_gh[0];
          res_d.gid_low  = e_gl[0];
          do_pop = 1'b1;
          cnt_d = cnt_q - 1'b1;
        end
      end
      OP_CLEAR: cnt_d = '0;
      OP_SCHED: begin
        dis_d = cmd_i.delay[15];
        if (!cmd_i.delay[15]) nrs_d = {1'b0, now_q} + {17'd0, cmd_i.delay};
      end
      OP_TICK: if (now_q != 32'hFFFF_FFFF) now_d = now_q + 32'd1;
      default: ;
    endcase
    pend_after = !dis_d && (nrs_d <= {1'b0, now_d});
    res_d.pending = pend_after;
    res_d.held = 6'(cnt_d);
  end

  // store: append at count, or shift toward head on pop
  always_ff @(posedge clk_i) begin
    if (go) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (do_pop && i < QueueDepth - 1) begin
          e_lid[i] <= e_lid[i+1]; e_pk[i] <= e_pk[i+1];
          e_gh[i]  <= e_gh[i+1];  e_gl[i] <= e_gl[i+1];
        end else if (do_add && i == int'(cnt_q)) begin
          e_lid[i] <= nlid; e_pk[i] <= cmd_i.pkey;
          e_gh[i]  <= ngh;  e_gl[i] <= ngl;
        end
      end
    end
    if (go) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; now_q <= '0; nrs_q <= '0; dis_q <= 1'b0; rv_q <= 1'b0;
    end else begin
      if (go) begin
        cnt_q <= cnt_d; now_q <= now_d; nrs_q <= nrs_d; dis_q <= dis_d;
      end
      if (go) rv_q <= 1'b1;
      else if (rtake_i) rv_q <= 1'b0;
    end
  end
endmodule

// ===== hw/rtl/dedup_task_queue_with_rescan.sv =====
// Flow: an accepted transaction waits in the front queue, then executes in the engine
//   once its result register is free; the result is held there until popped.
// Throughput is set by the engine's single result register, which must be popped
//   before the next command executes, so no command is taken while a result waits.
// Reset: rst_ni clears queue pointers, count, time, rescan state; a rescan
//   is pending after reset, so pushes are ignored until a schedule.
// ----------------------------------------------------------------------------
// dedup_task_queue_with_rescan
// Deduplicating discovery-task FIFO with rescan scheduling.
// ----------------------------------------------------------------------------
`include "dedup_task_queue_with_rescan_macros.svh"
module dedup_task_queue_with_rescan #(
  parameter int unsigned QUEUE_DEPTH = dtq_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation_i,
  input  logic [15:0] lid_in_i,
  input  logic [63:0] gid_high_in_i,
  input  logic [63:0] gid_low_in_i,
  input  logic [15:0] pkey_in_i,
  input  logic signed [15:0] delay_seconds_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [15:0] lid_out_o,
  output logic [63:0] gid_high_out_o,
  output logic [63:0] gid_low_out_o,
  output logic [15:0] pkey_out_o,
  output logic        rescan_pending_o,
  output logic [5:0]  entries_held_o,
  output logic        wake_main_o
);
  import dtq_pkg::*;

  cmd_t cin, cq;
  res_t res;
  logic cvalid, ctake, rvalid;

  assign cin = '{op: operation_i, lid: lid_in_i, gid_high: gid_high_in_i,
                 gid_low: gid_low_in_i, pkey: pkey_in_i,
                 delay: delay_seconds_i};

  // front: accepts transactions and buffers them
  dtq_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .cmd_i(cin),
    .cvalid_o(cvalid), .ctake_i(ctake), .cmd_o(cq)
  );

  // back: executes against the entry store, holds one result
  dtq_back #(.QueueDepth(QUEUE_DEPTH)) u_back (
    .clk_i, .rst_ni, .cvalid_i(cvalid), .ctake_o(ctake), .cmd_i(cq),
    .rvalid_o(rvalid), .rtake_i(pop), .res_o(res)
  );

  assign empty            = !rvalid;
  assign status_o         = res.status;
  assign lid_out_o        = res.lid;
  assign gid_high_out_o   = res.gid_high;
  assign gid_low_out_o    = res.gid_low;
  assign pkey_out_o       = res.pkey;
  assign rescan_pending_o = res.pending;
  assign entries_held_o   = res.held;
  assign wake_main_o      = res.wake;

  `DTQ_ASSERT(a_take_needs_room, clk_i, rst_ni, ctake |-> empty, "command taken while result waits")
  `DTQ_ASSERT(a_res_holds, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(status_o)), "result dropped")
  `DTQ_ASSERT(a_wake_push, clk_i, rst_ni, (!empty && wake_main_o) |-> (status_o == StAdded || status_o == StFlushed), "wake without add")
endmodule

// ===== bench/dedup_task_queue_with_rescan_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_task_queue_with_rescan_check
// Watches both queue ports, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module dedup_task_queue_with_rescan_check #(
  parameter int unsigned QUEUE_DEPTH = dtq_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  operation_i,
  input  logic [15:0] lid_in_i,
  input  logic [63:0] gid_high_in_i,
  input  logic [63:0] gid_low_in_i,
  input  logic [15:0] pkey_in_i,
  input  logic [15:0] delay_seconds_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  status_o,
  input  logic [15:0] lid_out_o,
  input  logic [63:0] gid_high_out_o,
  input  logic [63:0] gid_low_out_o,
  input  logic [15:0] pkey_out_o,
  input  logic        rescan_pending_o,
  input  logic [5:0]  entries_held_o,
  input  logic        wake_main_o,
  output int          errors_o,
  output int          outstanding_o,
  output int          flushes_o,
  output int          dups_o
);
  import dtq_pkg::*;

  logic [15:0] task_lid [QUEUE_DEPTH];
  logic [15:0] task_pkey[QUEUE_DEPTH];
  logic [63:0] task_gh  [QUEUE_DEPTH];
  logic [63:0] task_gl  [QUEUE_DEPTH];
  int unsigned task_count;
  logic [31:0] now_sec;
  logic [32:0] rescan_at;
  logic        rescan_off;
  res_t        expected_q[$];

  assign outstanding_o = expected_q.size();

  function automatic logic rescan_due();
    return !rescan_off && (rescan_at <= {1'b0, now_sec});
  endfunction

  function automatic logic [2:0] enqueue_task(logic by_gid, cmd_t c, ref logic wake);
    if (rescan_due()) return StIgnored;
    for (int i = 0; i < task_count; i++) begin
      if (task_pkey[i] == c.pkey) begin
        if (by_gid && task_gh[i] == c.gid_high && task_gl[i] == c.gid_low) return StDup;
        if (!by_gid && task_lid[i] == c.lid) return StDup;
      end
    end
    wake = 1'b1;
    if (task_count >= QUEUE_DEPTH) begin
      rescan_off = 1'b0;
      rescan_at  = {1'b0, now_sec};
      task_count = 0;
      return StFlushed;
    end
    task_lid[task_count]  = by_gid ? 16'd0 : c.lid;
    task_pkey[task_count] = c.pkey;
    task_gh[task_count]   = by_gid ? c.gid_high : 64'd0;
    task_gl[task_count]   = by_gid ? c.gid_low : 64'd0;
    task_count++;
    return StAdded;
  endfunction

  function automatic res_t predict_task_result(cmd_t c);
    res_t r;
    logic wake;
    r = '0;
    wake = 1'b0;
    r.status = StDone;
    case (c.op)
      OP_PUSH_LID: r.status = enqueue_task(1'b0, c, wake);
      OP_PUSH_GID: r.status = enqueue_task(1'b1, c, wake);
      OP_POP: begin
        if (task_count == 0) begin
          r.status = StEmpty;
        end else begin
          r.status = StPopped;
          r.lid = task_lid[0];
          r.pkey = task_pkey[0];
          r.gid_high = task_gh[0];
          r.gid_low = task_gl[0];
          for (int i = 1; i < task_count; i++) begin
            task_lid[i-1]  = task_lid[i];
            task_pkey[i-1] = task_pkey[i];
            task_gh[i-1]   = task_gh[i];
            task_gl[i-1]   = task_gl[i];
          end
          task_count--;
        end
      end
      OP_CLEAR: task_count = 0;
      OP_SCHED: begin
        rescan_off = c.delay[15];
        if (!c.delay[15]) rescan_at = {1'b0, now_sec} + {18'd0, c.delay[14:0]};
      end
      OP_TICK: if (now_sec != 32'hFFFF_FFFF) now_sec++;
      default: ;
    endcase
    r.pending = rescan_due();
    r.held = task_count[5:0];
    r.wake = wake;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    res_t e;
    if (!rst_ni) begin
      task_count = 0;
      now_sec = '0;
      rescan_at = '0;
      rescan_off = 1'b0;
      expected_q.delete();
      errors_o = 0;
      flushes_o = 0;
      dups_o = 0;
    end else begin
      if (push && !full) begin
        c = '{operation_i, lid_in_i, gid_high_in_i, gid_low_in_i, pkey_in_i, delay_seconds_i};
        e = predict_task_result(c);
        if (e.status == StFlushed) flushes_o++;
        if (e.status == StDup) dups_o++;
        expected_q.push_back(e);
      end
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no command waiting");
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o); errors_o++;
          end
          if (lid_out_o !== e.lid) begin
            $error("lid_out: expected %0h, got %0h", e.lid, lid_out_o); errors_o++;
          end
          if (gid_high_out_o !== e.gid_high) begin
            $error("gid_high_out: expected %0h, got %0h", e.gid_high, gid_high_out_o);
            errors_o++;
          end
          if (gid_low_out_o !== e.gid_low) begin
            $error("gid_low_out: expected %0h, got %0h", e.gid_low, gid_low_out_o);
            errors_o++;
          end
          if (pkey_out_o !== e.pkey) begin
            $error("pkey_out: expected %0h, got %0h", e.pkey, pkey_out_o); errors_o++;
          end
          if (rescan_pending_o !== e.pending) begin
            $error("rescan_pending: expected %0d, got %0d", e.pending, rescan_pending_o);
            errors_o++;
          end
          if (entries_held_o !== e.held) begin
            $error("entries_held: expected %0d, got %0d", e.held, entries_held_o);
            errors_o++;
          end
          if (wake_main_o !== e.wake) begin
            $error("wake_main: expected %0d, got %0d", e.wake, wake_main_o); errors_o++;
          end
        end
      end
    end
  end
endmodule

// ===== bench/dedup_task_queue_with_rescan_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_task_queue_with_rescan_test
// Directed and random command streams into the task queue, with bursty
// sending, a stalling receiver and one long hold-off that forces overflow.
// ----------------------------------------------------------------------------
module dedup_task_queue_with_rescan_test;
  import dtq_pkg::*;

  localparam logic [2:0] OpSpare6 = 3'd6;  // undefined codes, expect "done"
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam int RandomItems = 1000;
  localparam int IdleLimit   = 5000;       // well above the long hold-off
  localparam int HoldCycles  = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [2:0]  operation_i;
  logic [15:0] lid_in_i;
  logic [63:0] gid_high_in_i;
  logic [63:0] gid_low_in_i;
  logic [15:0] pkey_in_i;
  logic [15:0] delay_seconds_i;
  logic        empty;
  logic        pop;
  logic [2:0]  status_o;
  logic [15:0] lid_out_o;
  logic [63:0] gid_high_out_o;
  logic [63:0] gid_low_out_o;
  logic [15:0] pkey_out_o;
  logic        rescan_pending_o;
  logic [5:0]  entries_held_o;
  logic        wake_main_o;

  int errors;
  int outstanding;
  int flushes;
  int dups;
  int sent;
  int idle_cycles;
  logic hold_req;  // sender asks the receiver for one long stall

  dedup_task_queue_with_rescan DUT (.*);

  dedup_task_queue_with_rescan_check checker_i (
    .*,
    .errors_o(errors),
    .outstanding_o(outstanding),
    .flushes_o(flushes),
    .dups_o(dups)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: stall pattern is redrawn whenever its random run ends; a hold request
  // freezes it for a counted stretch so the block backs up into full.
  initial begin
    int mode;
    int left;
    pop = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(10, 60);
      end
      left--;
      case (mode)
        0: pop <= 1'b1;                          // no stalls
        1: pop <= ($urandom_range(0, 1) == 0);
        default: pop <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Watchdog: cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one command and hold it until accepted; push stays high afterward.
  task automatic send_cmd(cmd_t c);
    push <= 1'b1;
    operation_i <= c.op;
    lid_in_i <= c.lid;
    gid_high_in_i <= c.gid_high;
    gid_low_in_i <= c.gid_low;
    pkey_in_i <= c.pkey;
    delay_seconds_i <= c.delay;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
  endtask

  function automatic cmd_t mk(logic [2:0] op, logic [15:0] lid, logic [63:0] gh,
                              logic [63:0] gl, logic [15:0] pkey, logic [15:0] dly);
    cmd_t c;
    c = '{op, lid, gh, gl, pkey, dly};
    return c;
  endfunction

  // Small value pools make duplicates common; full-range values hit every bit.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c.lid = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    c.pkey = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      c.gid_high = {$urandom, $urandom};
      c.gid_low = {$urandom, $urandom};
    end else begin
      c.gid_high = 64'($urandom_range(0, 2));
      c.gid_low = 64'($urandom_range(0, 3));
    end
    case ($urandom_range(0, 3))
      0, 1: c.delay = 16'hFFFF;                      // disable, keeps pushes live
      2: c.delay = 16'($urandom_range(0, 3));
      default: c.delay = 16'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 32) c.op = OP_PUSH_LID;
    else if (pick < 58) c.op = OP_PUSH_GID;
    else if (pick < 78) c.op = OP_POP;
    else if (pick < 81) c.op = OP_CLEAR;
    else if (pick < 88) c.op = OP_SCHED;
    else if (pick < 96) c.op = OP_TICK;
    else c.op = (pick < 98) ? OpSpare6 : OpSpare7;
    return c;
  endfunction

  initial begin
    cmd_t dir_q[$];
    int burst;
    int gap;
    int n;
    rst_ni = 1'b0;
    push = 1'b0;
    hold_req = 1'b0;
    operation_i = '0;
    lid_in_i = '0;
    gid_high_in_i = '0;
    gid_low_in_i = '0;
    pkey_in_i = '0;
    delay_seconds_i = '0;
    sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rescan pending at start, empty pop, spare codes, LID/GID zero
    // cross matches, extremes of every field.
    dir_q.push_back(mk(OP_PUSH_LID, 16'hFFFF, '0, '0, 16'hFFFF, '0));
    dir_q.push_back(mk(OP_PUSH_GID, '0, '1, '1, 16'hFFFF, '0));
    dir_q.push_back(mk(OP_POP, '0, '0, '0, '0, '0));
    dir_q.push_back(mk(OpSpare6, '1, '1, '1, '1, '1));
    dir_q.push_back(mk(OpSpare7, '0, '0, '0, '0, '0));
    dir_q.push_back(mk(OP_TICK, '0, '0, '0, '0, '0));
    dir_q.push_back(mk(OP_SCHED, '0, '0, '0, '0, 16'd0));       // due right now
    dir_q.push_back(mk(OP_SCHED, '0, '0, '0, '0, 16'h7FFF));    // far future
    dir_q.push_back(mk(OP_PUSH_LID, 16'd0, '0, '0, 16'd5, '0));
    dir_q.push_back(mk(OP_PUSH_GID, '0, '1, '1, 16'hFFFF, '0));
    dir_q.push_back(mk(OP_PUSH_GID, '0, '0, '0, 16'd5, '0));    // GID zero vs LID entry
    dir_q.push_back(mk(OP_PUSH_LID, 16'd0, '0, '0, 16'hFFFF, '0)); // LID zero vs GID entry
    dir_q.push_back(mk(OP_PUSH_LID, 16'hFFFF, '0, '0, 16'd0, '0));
    dir_q.push_back(mk(OP_PUSH_LID, 16'hFFFF, '0, '0, 16'd0, '0));
    dir_q.push_back(mk(OP_POP, '0, '0, '0, '0, '0));
    dir_q.push_back(mk(OP_CLEAR, '0, '0, '0, '0, '0));
    dir_q.push_back(mk(OP_SCHED, '0, '0, '0, '0, 16'hFFFF));    // disable
    dir_q.push_back(mk(OP_SCHED, '0, '0, '0, '0, 16'h8000));
    dir_q.push_back(mk(OP_TICK, '0, '0, '0, '0, '0));
    dir_q.push_back(mk(OP_PUSH_GID, '0, 64'hA5A5_5A5A_0F0F_F0F0, 64'h1234_5678_9ABC_DEF0,
                       16'h8001, '0));
    dir_q.push_back(mk(OP_POP, '0, '0, '0, '0, '0));
    dir_q.push_back(mk(OP_POP, '0, '0, '0, '0, '0));
    dir_q.push_back(mk(OP_POP, '0, '0, '0, '0, '0));
    foreach (dir_q[i]) send_cmd(dir_q[i]);

    // Pressure: receiver stalls while distinct pushes overrun the queue,
    // so the block both flushes on overflow and backs up into full.
    send_cmd(mk(OP_SCHED, '0, '0, '0, '0, 16'hFFFF));
    send_cmd(mk(OP_CLEAR, '0, '0, '0, '0, '0));
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    for (int i = 0; i < 40; i++)
      send_cmd(mk(OP_PUSH_LID, 16'(i + 1), '0, '0, 16'(i), '0));

    // Random bursts with gaps; some bursts run back to back.
    n = 0;
    while (n < RandomItems) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && n < RandomItems; i++) begin
        send_cmd(random_cmd());
        n++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    push <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d command transactions: %0d duplicates dropped, %0d overflow flushes.",
             sent, dups, flushes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
